>>> rtl/core/multiple_recursive_generator_macros.svh
// assertion macros for the multiple recursive generator top level
// expects clk and rst_n in the scope where a macro is used
`ifndef MULTIPLE_RECURSIVE_GENERATOR_MACROS_SVH
`define MULTIPLE_RECURSIVE_GENERATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MRG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mrg_pkg.sv
// shared constants, word types, codes and control structs for the generator
// no dependencies
`timescale 1ns / 1ps

package mrg_pkg;

  localparam int MAX_ORDER = 4;
  localparam int MOD_BITS  = 32;
  localparam int POS_BITS  = 31;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ORD_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = $clog2(MOD_BITS + 1);
  localparam int MEM_AW    = 1 + 2 * IDX_W;
  localparam int MEM_DEPTH = 2 ** MEM_AW;

  localparam logic [MOD_BITS-1:0] MOD_RESET   = MOD_BITS'(64'd2147483647);
  localparam logic [ORD_W-1:0]    ORDER_RESET = ORD_W'(1);
  localparam logic [POS_BITS-1:0] POS_MAX     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS = 3'd0,
    CFG_ORDER   = 3'd1,
    CFG_COEFF_1 = 3'd2,
    CFG_COEFF_2 = 3'd3,
    CFG_COEFF_3 = 3'd4,
    CFG_COEFF_4 = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_SEED = 2'd0,
    OP_NEXT = 2'd1,
    OP_JUMP = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEED_WAIT,
    S_CHECK,
    S_BUILD,
    S_BUILD_WAIT,
    S_LOOP,
    S_RD,
    S_MUL,
    S_WAIT,
    S_WB,
    S_COPY,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_SEED,
    PH_BUILD,
    PH_APPLY,
    PH_SQUARE
  } phase_t;

  typedef enum logic [1:0] {
    WS_ZERO,
    WS_ONE,
    WS_PROD,
    WS_ACC
  } wsrc_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [1:0]          seed_slot;
    logic [MOD_BITS-1:0] seed_value;
    logic [POS_BITS-1:0] target_index;
  } in_word_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] value;
    logic [POS_BITS-1:0] position;
  } out_word_t;

  typedef struct packed {
    logic             capture;
    logic             steps_load;
    logic             steps_shift;
    phase_t           phase;
    logic             mul_start;
    logic             mem_rd;
    logic             mem_wr;
    logic             wr_other;
    wsrc_t            wsrc;
    logic             acc_clr;
    logic             acc_add;
    logic             tvec_wr;
    logic             hist_copy;
    logic             seed_wr;
    logic             bank_flip;
    logic             out_load;
    logic [IDX_W-1:0] idx_i;
    logic [IDX_W-1:0] idx_j;
    logic [IDX_W-1:0] idx_l;
  } mrg_cmd_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] km1;
    logic             steps_zero;
    logic             steps_lsb;
    logic             steps_last;
    logic             mul_done;
    logic             out_free;
  } mrg_status_t;

endpackage

>>> rtl/core/mrg_modmul.sv
// serial modular multiplier: prod = (op_a * op_b) mod modulus, one bit of op_b a cycle
// needs op_a already reduced; uses mrg_pkg
`timescale 1ns / 1ps

module mrg_modmul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mrg_pkg::MOD_BITS-1:0]  op_a,
  input  logic [mrg_pkg::MOD_BITS-1:0]  op_b,
  input  logic [mrg_pkg::MOD_BITS:0]    modulus,
  output logic                          done,
  output logic [mrg_pkg::MOD_BITS-1:0]  prod
);

  logic                          busy_r;
  logic                          done_r;
  logic [mrg_pkg::CNT_W-1:0]     cnt_r;
  logic [mrg_pkg::MOD_BITS-1:0]  r_r;
  logic [mrg_pkg::MOD_BITS-1:0]  a_r;
  logic [mrg_pkg::MOD_BITS-1:0]  b_r;
  logic [mrg_pkg::MOD_BITS-1:0]  r_nxt;
  logic [mrg_pkg::MOD_BITS:0]    dbl;
  logic [mrg_pkg::MOD_BITS:0]    dred;
  logic [mrg_pkg::MOD_BITS:0]    sum;
  logic [mrg_pkg::MOD_BITS:0]    sred;

  // msb-first horner step: r = (2r + bit * a) mod m, both halves stay below 2m
  always_comb begin
    dbl  = {r_r, 1'b0};
    dred = (dbl >= modulus) ? dbl - modulus : dbl;
    sum  = dred + (b_r[mrg_pkg::MOD_BITS-1] ? {1'b0, a_r} : '0);
    sred = (sum >= modulus) ? sum - modulus : sum;
    r_nxt = sred[mrg_pkg::MOD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // zero multiplicand finishes at once
        busy_r <= (op_a != '0);
        done_r <= (op_a == '0);
        cnt_r  <= mrg_pkg::CNT_W'(mrg_pkg::MOD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - mrg_pkg::CNT_W'(1);
        if (cnt_r == mrg_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      b_r <= op_b;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= b_r << 1;
    end
  end

  assign done = done_r;
  assign prod = r_r;

endmodule

>>> rtl/core/mrg_datapath.sv
// generator datapath: config registers, history, matrix memory, accumulator, output word
// uses mrg_pkg and mrg_modmul
`timescale 1ns / 1ps

module mrg_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mrg_pkg::mrg_cmd_t               cmd,
  output mrg_pkg::mrg_status_t            sts,
  input  mrg_pkg::in_word_t               in_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mrg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrg_pkg::MOD_BITS-1:0]    cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mrg_pkg::out_word_t              out_word
);

  logic [mrg_pkg::MOD_BITS-1:0]  modulus_r;
  logic [mrg_pkg::ORD_W-1:0]     order_r;
  logic [mrg_pkg::MOD_BITS-1:0]  coeff_r [mrg_pkg::MAX_ORDER];
  logic [mrg_pkg::MOD_BITS-1:0]  hist_r  [mrg_pkg::MAX_ORDER];
  logic [mrg_pkg::MOD_BITS-1:0]  tvec_r  [mrg_pkg::MAX_ORDER];
  logic [mrg_pkg::POS_BITS-1:0]  step_count_r;
  logic [mrg_pkg::POS_BITS-1:0]  step_count_nxt;
  logic [mrg_pkg::POS_BITS-1:0]  steps_r;
  logic [mrg_pkg::POS_BITS-1:0]  steps_nxt;
  mrg_pkg::in_word_t             in_r;
  logic [mrg_pkg::MOD_BITS-1:0]  acc_r;
  logic [mrg_pkg::MOD_BITS-1:0]  acc_nxt;
  logic                          bank_r;
  logic                          out_valid_r;
  mrg_pkg::out_word_t            out_word_r;
  logic [mrg_pkg::MOD_BITS-1:0]  mat_mem [mrg_pkg::MEM_DEPTH];
  logic [mrg_pkg::MOD_BITS-1:0]  rd_a_r;
  logic [mrg_pkg::MOD_BITS-1:0]  rd_b_r;

  logic [mrg_pkg::MOD_BITS:0]    m_eff;
  logic [mrg_pkg::MOD_BITS-1:0]  one_mod;
  logic [mrg_pkg::IDX_W-1:0]     km1;
  logic [mrg_pkg::IDX_W-1:0]     hist_idx;
  logic [mrg_pkg::MOD_BITS-1:0]  hist_rd;
  logic [mrg_pkg::CFG_IDX_W-1:0] coeff_sel;
  logic [mrg_pkg::MOD_BITS-1:0]  mul_a;
  logic [mrg_pkg::MOD_BITS-1:0]  mul_b;
  logic                          mul_done;
  logic [mrg_pkg::MOD_BITS-1:0]  prod;
  logic [mrg_pkg::MOD_BITS:0]    acc_sum;
  logic [mrg_pkg::MEM_AW-1:0]    addr_a;
  logic [mrg_pkg::MEM_AW-1:0]    addr_b;
  logic [mrg_pkg::MEM_AW-1:0]    addr_w;
  logic [mrg_pkg::MOD_BITS-1:0]  wdata;

  // modulus zero means 2^MOD_BITS
  assign m_eff   = {modulus_r == '0, modulus_r};
  assign one_mod = (modulus_r == mrg_pkg::MOD_BITS'(1)) ? '0 : mrg_pkg::MOD_BITS'(1);

  always_comb begin
    if (order_r == '0) begin
      km1 = '0;
    end else if (32'(order_r) > mrg_pkg::MAX_ORDER) begin
      km1 = mrg_pkg::IDX_W'(mrg_pkg::MAX_ORDER - 1);
    end else begin
      km1 = mrg_pkg::IDX_W'(order_r - mrg_pkg::ORD_W'(1));
    end
  end

  assign hist_idx = cmd.out_load ? km1 : cmd.idx_l;
  assign hist_rd  = hist_r[hist_idx];

  assign cfg_ready = 1'b1;
  assign coeff_sel = cfg_index - mrg_pkg::CFG_COEFF_1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mrg_pkg::MOD_RESET;
      order_r   <= mrg_pkg::ORDER_RESET;
      for (int i = 0; i < mrg_pkg::MAX_ORDER; i++) begin
        coeff_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == mrg_pkg::CFG_MODULUS) begin
        modulus_r <= cfg_data;
      end else if (cfg_index == mrg_pkg::CFG_ORDER) begin
        order_r <= cfg_data[mrg_pkg::ORD_W-1:0];
      end else if (cfg_index >= mrg_pkg::CFG_COEFF_1 && cfg_index <= mrg_pkg::CFG_COEFF_4) begin
        coeff_r[coeff_sel[mrg_pkg::IDX_W-1:0]] <= cfg_data;
      end
    end
  end

  // operand routing for the shared multiplier
  always_comb begin
    case (cmd.phase)
      mrg_pkg::PH_SEED: begin
        mul_a = one_mod;
        mul_b = in_r.seed_value;
      end
      mrg_pkg::PH_BUILD: begin
        mul_a = one_mod;
        mul_b = coeff_r[km1 - cmd.idx_j];
      end
      mrg_pkg::PH_APPLY: begin
        mul_a = rd_a_r;
        mul_b = hist_rd;
      end
      mrg_pkg::PH_SQUARE: begin
        mul_a = rd_a_r;
        mul_b = rd_b_r;
      end
      default: begin
        mul_a = one_mod;
        mul_b = in_r.seed_value;
      end
    endcase
  end

  mrg_modmul u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (m_eff),
    .done    (mul_done),
    .prod    (prod)
  );

  assign acc_sum = {1'b0, acc_r} + {1'b0, prod};
  assign acc_nxt = (acc_sum >= m_eff) ? mrg_pkg::MOD_BITS'(acc_sum - m_eff)
                                      : acc_sum[mrg_pkg::MOD_BITS-1:0];

  // step count and remaining steps for a new word
  always_comb begin
    steps_nxt      = '0;
    step_count_nxt = step_count_r;
    case (in_r.opcode)
      mrg_pkg::OP_NEXT: begin
        steps_nxt = mrg_pkg::POS_BITS'(1);
        if (step_count_r != mrg_pkg::POS_MAX) begin
          step_count_nxt = step_count_r + mrg_pkg::POS_BITS'(1);
        end
      end
      mrg_pkg::OP_JUMP: begin
        if (in_r.target_index > step_count_r) begin
          steps_nxt      = in_r.target_index - step_count_r;
          step_count_nxt = in_r.target_index;
        end
      end
      default: begin
        steps_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= '0;
      steps_r      <= '0;
      acc_r        <= '0;
      bank_r       <= 1'b0;
      for (int i = 0; i < mrg_pkg::MAX_ORDER; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cmd.steps_load) begin
        steps_r      <= steps_nxt;
        step_count_r <= step_count_nxt;
      end else if (cmd.steps_shift) begin
        steps_r <= steps_r >> 1;
      end
      if (cmd.seed_wr) begin
        step_count_r <= '0;
        if (32'(in_r.seed_slot) < mrg_pkg::MAX_ORDER) begin
          hist_r[in_r.seed_slot] <= prod;
        end
      end
      if (cmd.acc_clr) begin
        acc_r <= '0;
      end else if (cmd.acc_add) begin
        acc_r <= acc_nxt;
      end
      if (cmd.hist_copy) begin
        for (int i = 0; i < mrg_pkg::MAX_ORDER; i++) begin
          if (mrg_pkg::IDX_W'(i) <= km1) begin
            hist_r[i] <= tvec_r[i];
          end
        end
      end
      if (cmd.bank_flip) begin
        bank_r <= ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_word;
    end
    if (cmd.tvec_wr) begin
      tvec_r[cmd.idx_i] <= acc_r;
    end
  end

  // matrix memory: two banks of a k x k matrix, squares ping-pong between them
  assign addr_a = {bank_r, cmd.idx_i, cmd.idx_l};
  assign addr_b = {bank_r, cmd.idx_l, cmd.idx_j};
  assign addr_w = {bank_r ^ cmd.wr_other, cmd.idx_i, cmd.idx_j};

  always_comb begin
    case (cmd.wsrc)
      mrg_pkg::WS_ZERO: wdata = '0;
      mrg_pkg::WS_ONE:  wdata = one_mod;
      mrg_pkg::WS_PROD: wdata = prod;
      mrg_pkg::WS_ACC:  wdata = acc_r;
      default:          wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mat_mem[addr_w] <= wdata;
    end
    if (cmd.mem_rd) begin
      rd_a_r <= mat_mem[addr_a];
      rd_b_r <= mat_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r.value    <= hist_rd;
      out_word_r.position <= step_count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign sts.opcode     = in_r.opcode;
  assign sts.km1        = km1;
  assign sts.steps_zero = (steps_r == '0);
  assign sts.steps_lsb  = steps_r[0];
  assign sts.steps_last = (steps_r[mrg_pkg::POS_BITS-1:1] == '0);
  assign sts.mul_done   = mul_done;
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

>>> rtl/core/mrg_ctrl.sv
// generator controller: sequences seed load, matrix build, apply and square passes
// uses mrg_pkg
`timescale 1ns / 1ps

module mrg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mrg_pkg::mrg_status_t  sts,
  output mrg_pkg::mrg_cmd_t     cmd
);

  mrg_pkg::state_t              state_r;
  mrg_pkg::state_t              state_nxt;
  mrg_pkg::phase_t              phase_r;
  mrg_pkg::phase_t              phase_nxt;
  logic [mrg_pkg::IDX_W-1:0]    i_r;
  logic [mrg_pkg::IDX_W-1:0]    i_nxt;
  logic [mrg_pkg::IDX_W-1:0]    j_r;
  logic [mrg_pkg::IDX_W-1:0]    j_nxt;
  logic [mrg_pkg::IDX_W-1:0]    l_r;
  logic [mrg_pkg::IDX_W-1:0]    l_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrg_pkg::S_IDLE;
      phase_r <= mrg_pkg::PH_SEED;
      i_r     <= '0;
      j_r     <= '0;
      l_r     <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      l_r     <= l_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    l_nxt     = l_r;
    cmd       = '0;
    cmd.phase = phase_r;
    cmd.idx_i = i_r;
    cmd.idx_j = j_r;
    cmd.idx_l = l_r;
    case (state_r)
      mrg_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = mrg_pkg::S_DECODE;
        end
      end
      mrg_pkg::S_DECODE: begin
        if (sts.opcode == mrg_pkg::OP_SEED) begin
          cmd.phase     = mrg_pkg::PH_SEED;
          phase_nxt     = mrg_pkg::PH_SEED;
          cmd.mul_start = 1'b1;
          state_nxt     = mrg_pkg::S_SEED_WAIT;
        end else begin
          cmd.steps_load = 1'b1;
          state_nxt      = mrg_pkg::S_CHECK;
        end
      end
      mrg_pkg::S_SEED_WAIT: begin
        if (sts.mul_done) begin
          cmd.seed_wr = 1'b1;
          state_nxt   = mrg_pkg::S_OUT;
        end
      end
      mrg_pkg::S_CHECK: begin
        if (sts.steps_zero) begin
          state_nxt = mrg_pkg::S_OUT;
        end else begin
          phase_nxt = mrg_pkg::PH_BUILD;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = mrg_pkg::S_BUILD;
        end
      end
      mrg_pkg::S_BUILD: begin
        // last row holds reduced coefficients, rows above are the shift
        if (i_r == sts.km1) begin
          cmd.mul_start = 1'b1;
          state_nxt     = mrg_pkg::S_BUILD_WAIT;
        end else begin
          cmd.mem_wr = 1'b1;
          cmd.wsrc   = (j_r == i_r + mrg_pkg::IDX_W'(1)) ? mrg_pkg::WS_ONE : mrg_pkg::WS_ZERO;
          if (j_r == sts.km1) begin
            j_nxt = '0;
            i_nxt = i_r + mrg_pkg::IDX_W'(1);
          end else begin
            j_nxt = j_r + mrg_pkg::IDX_W'(1);
          end
        end
      end
      mrg_pkg::S_BUILD_WAIT: begin
        if (sts.mul_done) begin
          cmd.mem_wr = 1'b1;
          cmd.wsrc   = mrg_pkg::WS_PROD;
          if (j_r == sts.km1) begin
            i_nxt     = '0;
            j_nxt     = '0;
            l_nxt     = '0;
            state_nxt = mrg_pkg::S_LOOP;
          end else begin
            j_nxt     = j_r + mrg_pkg::IDX_W'(1);
            state_nxt = mrg_pkg::S_BUILD;
          end
        end
      end
      mrg_pkg::S_LOOP: begin
        i_nxt = '0;
        j_nxt = '0;
        l_nxt = '0;
        if (sts.steps_zero) begin
          state_nxt = mrg_pkg::S_OUT;
        end else if (sts.steps_lsb) begin
          cmd.acc_clr = 1'b1;
          phase_nxt   = mrg_pkg::PH_APPLY;
          state_nxt   = mrg_pkg::S_RD;
        end else begin
          cmd.acc_clr     = 1'b1;
          cmd.steps_shift = 1'b1;
          phase_nxt       = mrg_pkg::PH_SQUARE;
          state_nxt       = mrg_pkg::S_RD;
        end
      end
      mrg_pkg::S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = mrg_pkg::S_MUL;
      end
      mrg_pkg::S_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = mrg_pkg::S_WAIT;
      end
      mrg_pkg::S_WAIT: begin
        if (sts.mul_done) begin
          cmd.acc_add = 1'b1;
          if (l_r == sts.km1) begin
            state_nxt = mrg_pkg::S_WB;
          end else begin
            l_nxt     = l_r + mrg_pkg::IDX_W'(1);
            state_nxt = mrg_pkg::S_RD;
          end
        end
      end
      mrg_pkg::S_WB: begin
        cmd.acc_clr = 1'b1;
        l_nxt       = '0;
        if (phase_r == mrg_pkg::PH_APPLY) begin
          cmd.tvec_wr = 1'b1;
          if (i_r == sts.km1) begin
            state_nxt = mrg_pkg::S_COPY;
          end else begin
            i_nxt     = i_r + mrg_pkg::IDX_W'(1);
            state_nxt = mrg_pkg::S_RD;
          end
        end else begin
          // squared entry goes to the other bank
          cmd.mem_wr   = 1'b1;
          cmd.wr_other = 1'b1;
          cmd.wsrc     = mrg_pkg::WS_ACC;
          if (j_r == sts.km1) begin
            j_nxt = '0;
            if (i_r == sts.km1) begin
              cmd.bank_flip = 1'b1;
              i_nxt         = '0;
              state_nxt     = mrg_pkg::S_LOOP;
            end else begin
              i_nxt     = i_r + mrg_pkg::IDX_W'(1);
              state_nxt = mrg_pkg::S_RD;
            end
          end else begin
            j_nxt     = j_r + mrg_pkg::IDX_W'(1);
            state_nxt = mrg_pkg::S_RD;
          end
        end
      end
      mrg_pkg::S_COPY: begin
        cmd.hist_copy   = 1'b1;
        cmd.steps_shift = 1'b1;
        i_nxt           = '0;
        j_nxt           = '0;
        l_nxt           = '0;
        if (sts.steps_last) begin
          state_nxt = mrg_pkg::S_OUT;
        end else begin
          phase_nxt = mrg_pkg::PH_SQUARE;
          state_nxt = mrg_pkg::S_RD;
        end
      end
      mrg_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = mrg_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mrg_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != mrg_pkg::S_IDLE);

endmodule

>>> rtl/core/multiple_recursive_generator.sv
// multiple recursive generator top level, one word in flight, a waiting result lets the next word in
// next/jump: build the matrix, then per set step-count bit apply it to the history and
//   per bit below the top square it, then load the result
// synchronous active-low reset restores register defaults and clears history and position
`timescale 1ns / 1ps

module multiple_recursive_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mrg_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mrg_pkg::out_word_t             out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrg_pkg::MOD_BITS-1:0]   cfg_data
);

  mrg_pkg::mrg_cmd_t    cmd;
  mrg_pkg::mrg_status_t sts;

  mrg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrg_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`include "multiple_recursive_generator_macros.svh"

  // one word at a time: the cycle after an accept the input is held off
  `MRG_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "word accepted while busy")
  // multiplier results only arrive while a word is being worked on
  `MRG_ASSERT_SAME(a_mul_busy, sts.mul_done, in_stall, "multiplier done while idle")
  // a loaded result is presented on the next cycle
  `MRG_ASSERT_NEXT(a_out_loaded, cmd.out_load, out_valid, "result load lost")
  // a result is only loaded when the output register is free
  `MRG_ASSERT_SAME(a_out_free, cmd.out_load, !out_valid || !out_stall, "result overwritten")

endmodule
